/* hw/rtl/lpt_pkg.sv */
`default_nettype none
package lpt_pkg;

  localparam int MAX_SAMPLES = 256;
  localparam int DATA_W      = 32;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int COUNT_W     = 9;
  localparam int PROD_W      = $clog2(MAX_SAMPLES * 1000 + 1);

  localparam logic [PROD_W-1:0] PERMILLE_P50  = PROD_W'(500);
  localparam logic [PROD_W-1:0] PERMILLE_P99  = PROD_W'(990);
  localparam logic [PROD_W-1:0] PERMILLE_P999 = PROD_W'(999);
  localparam logic [PROD_W-1:0] PERMILLE_ONE  = PROD_W'(1000);

  localparam logic CMD_RECORD  = 1'b0;
  localparam logic CMD_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } lpt_state_t;

  typedef struct packed {
    logic              insert;
    logic              rotate;
    logic [DATA_W-1:0] value;
  } lpt_chain_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/lpt_cell.sv */
`default_nettype none
module lpt_cell
  import lpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lpt_chain_ctl_t    ctl,
  input  wire logic              prev_valid,
  input  wire logic [DATA_W-1:0] prev_value,
  input  wire logic              prev_gt,
  output logic                   valid,
  output logic [DATA_W-1:0]      value,
  output logic                   gt
);

  logic              valid_next;
  logic [DATA_W-1:0] value_next;

  assign gt = !valid || (value > ctl.value);

  always_comb begin
    valid_next = valid;
    value_next = value;
    if (ctl.insert && gt) begin
      if (prev_gt) begin
        valid_next = prev_valid;
        value_next = prev_value;
      end else begin
        valid_next = 1'b1;
        value_next = ctl.value;
      end
    end else if (ctl.rotate) begin
      valid_next = prev_valid;
      value_next = prev_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule
`default_nettype wire

/* hw/rtl/lpt_chain.sv */
`default_nettype none
module lpt_chain
  import lpt_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire lpt_chain_ctl_t ctl,
  output logic [DATA_W-1:0]   head_value
);

  logic              valid_w [MAX_SAMPLES];
  logic [DATA_W-1:0] value_w [MAX_SAMPLES];
  logic              gt_w    [MAX_SAMPLES];

  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    if (i == 0) begin : g_first
      lpt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_valid (valid_w[MAX_SAMPLES-1]),
        .prev_value (value_w[MAX_SAMPLES-1]),
        .prev_gt    (1'b0),
        .valid      (valid_w[i]),
        .value      (value_w[i]),
        .gt         (gt_w[i])
      );
    end else begin : g_rest
      lpt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctl        (ctl),
        .prev_valid (valid_w[i-1]),
        .prev_value (value_w[i-1]),
        .prev_gt    (gt_w[i-1]),
        .valid      (valid_w[i]),
        .value      (value_w[i]),
        .gt         (gt_w[i])
      );
    end
  end

  assign head_value = value_w[MAX_SAMPLES-1];

endmodule
`default_nettype wire

/* hw/rtl/lpt_ctrl.sv */
`default_nettype none
module lpt_ctrl
  import lpt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              command,
  input  wire logic [DATA_W-1:0] sample_in,
  input  wire logic [DATA_W-1:0] head_value,
  output lpt_chain_ctl_t         ctl,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [DATA_W-1:0]      median_ns,
  output logic [DATA_W-1:0]      pct99_ns,
  output logic [DATA_W-1:0]      pct999_ns,
  output logic [COUNT_W-1:0]     stored_count,
  output logic                   dropped_flag
);

  lpt_state_t        state, state_next;
  logic [CNT_W-1:0]  count;
  logic              overflow;
  logic [IDX_W-1:0]  step;
  logic [PROD_W-1:0] thr;
  logic [PROD_W-1:0] nk50, nk99, nk999;
  logic [DATA_W-1:0] cap50, cap99, cap999;
  logic              accept, load_out, full;
  logic              hit50, hit99, hit999;

  assign full = (count == CNT_W'(MAX_SAMPLES));

  assign hit50  = (thr < nk50)  && (nk50  <= thr + PERMILLE_ONE);
  assign hit99  = (thr < nk99)  && (nk99  <= thr + PERMILLE_ONE);
  assign hit999 = (thr < nk999) && (nk999 <= thr + PERMILLE_ONE);

  always_comb begin
    in_ready   = (state == ST_IDLE);
    accept     = in_valid && in_ready;
    load_out   = (state == ST_DONE) && (!out_valid || out_ready);
    ctl.insert = accept && (command == CMD_RECORD) && !full;
    ctl.rotate = (state == ST_SCAN);
    ctl.value  = sample_in;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (command == CMD_SUMMARY)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (step == IDX_W'(MAX_SAMPLES - 1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      overflow  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.insert) count <= count + CNT_W'(1);
      if (accept && (command == CMD_RECORD) && full) overflow <= 1'b1;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (command == CMD_SUMMARY)) begin
      step   <= '0;
      thr    <= PROD_W'(MAX_SAMPLES - 1) * PERMILLE_ONE;
      nk50   <= PROD_W'(count) * PERMILLE_P50;
      nk99   <= PROD_W'(count) * PERMILLE_P99;
      nk999  <= PROD_W'(count) * PERMILLE_P999;
      cap50  <= '0;
      cap99  <= '0;
      cap999 <= '0;
    end else if (state == ST_SCAN) begin
      step <= step + IDX_W'(1);
      thr  <= thr - PERMILLE_ONE;
      if (hit50)  cap50  <= head_value;
      if (hit99)  cap99  <= head_value;
      if (hit999) cap999 <= head_value;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      median_ns    <= cap50;
      pct99_ns     <= cap99;
      pct999_ns    <= cap999;
      stored_count <= COUNT_W'(count);
      dropped_flag <= overflow;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/latency_percentile_tracker_unit.sv */
`default_nettype none
// Nearest-rank latency percentile tracker. A record word (s_tuser = 0) inserts
// its sample into a sorted row of 256 cells, so records can be sent back to back;
// once 256 samples are held further records are dropped and the sticky dropped
// flag is set. A summary word (s_tuser = 1) rotates the whole cell row once past
// its last cell to pick out the p50, p99 and p99.9 samples: the result appears
// once the rotation is done (later if m_tready still holds the previous result),
// and s_tready stays low until then. An empty store reports zero percentiles.
module latency_percentile_tracker_unit
  import lpt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [31:0]  s_tdata,   // [31:0] latency sample
  input  wire logic         s_tuser,   // [0] command
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [111:0]      m_tdata    // [31:0] median_ns, [63:32] pct99_ns,
                                       // [95:64] pct999_ns, [104:96] stored_count,
                                       // [105] dropped_flag, [111:106] zero
);

  lpt_chain_ctl_t     ctl;
  logic [DATA_W-1:0]  head_value;
  logic [DATA_W-1:0]  median_ns, pct99_ns, pct999_ns;
  logic [COUNT_W-1:0] stored_count;
  logic               dropped_flag;

  lpt_chain u_chain (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .head_value (head_value)
  );

  lpt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .command      (s_tuser),
    .sample_in    (s_tdata),
    .head_value   (head_value),
    .ctl          (ctl),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .median_ns    (median_ns),
    .pct99_ns     (pct99_ns),
    .pct999_ns    (pct999_ns),
    .stored_count (stored_count),
    .dropped_flag (dropped_flag)
  );

  assign m_tdata = {6'b0, dropped_flag, stored_count, pct999_ns, pct99_ns, median_ns};

  a_no_insert_while_rotating: assert property (@(posedge clk) disable iff (rst)
    !(ctl.insert && ctl.rotate))
    else $error("insert and rotate together");

  a_busy_after_summary: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tuser == CMD_SUMMARY)) |=> !s_tready)
    else $error("input taken during summary scan");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[104:96] <= COUNT_W'(MAX_SAMPLES)))
    else $error("stored count beyond capacity");

  a_insert_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    ctl.insert |-> (s_tvalid && s_tready && (s_tuser == CMD_RECORD)))
    else $error("insert without an accepted record");

endmodule
`default_nettype wire
